[src/zvf_pkg.sv]
// Shared types and constants for the voxel z-score fraction block.
// Used by every module in src; depends on nothing.
`default_nettype none
package zvf_pkg;

	localparam int COUNT_BITS    = 24;
	localparam int FRACTION_BITS = 16;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int VAL_W         = 16;
	localparam int LHS_W         = 46;
	localparam int PROD_W        = 48;
	localparam int CMP_W         = 50;
	localparam int STEP_W        = $clog2(FRACTION_BITS + 1);

	localparam logic [1:0] REG_REF_MEAN    = 2'd0;
	localparam logic [1:0] REG_BELOW_MODE  = 2'd1;
	localparam logic [1:0] REG_Z_THRESHOLD = 2'd2;

	localparam logic [VAL_W-1:0] REF_MEAN_RST    = 16'd4096;
	localparam logic [VAL_W-1:0] Z_THRESHOLD_RST = 16'd6758;

	typedef struct packed {
		logic [15:0] voxel_value;
		logic [15:0] template_mean;
		logic [15:0] template_std;
		logic        in_roi;
		logic        last_voxel;
	} vox_t;

	typedef struct packed {
		logic                  mask_bit;
		logic [COUNT_BITS-1:0] counted_total;
		logic [COUNT_BITS-1:0] positive_total;
		logic [FRAC_W-1:0]     fill_fraction;
		logic                  image_done;
	} res_t;

	typedef struct packed {
		logic [VAL_W-1:0] ref_mean;
		logic             below_mode;
		logic [VAL_W-1:0] z_threshold;
	} cfg_t;

	// classified voxel handed from front to back
	typedef struct packed {
		logic counted;
		logic pos;
		logic last;
	} cls_t;

endpackage
`default_nettype wire

[src/zvf_front.sv]
// Front end: accepts voxels and classifies them with the exact z-score test.
// Two multiply stages then a compare at the queue push; uses zvf_pkg.
`default_nettype none
module zvf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire zvf_pkg::cfg_t  cfg,
	input  wire logic           vox_valid,
	output logic                vox_stall,
	input  wire zvf_pkg::vox_t  vox,
	output logic                push,
	output zvf_pkg::cls_t       push_data,
	input  wire logic           q_full
);

	logic [zvf_pkg::VAL_W-1:0]  ref_nz;
	logic                       valid_s1;
	logic [31:0]                mr_s1;
	logic [31:0]                ts_s1;
	logic [zvf_pkg::VAL_W-1:0]  value_s1;
	logic                       counted_s1;
	logic                       last_s1;
	logic                       valid_s2;
	logic signed [zvf_pkg::LHS_W-1:0] lhs_s2;
	logic [zvf_pkg::PROD_W-1:0] tsr_s2;
	logic                       counted_s2;
	logic                       last_s2;
	logic                       adv_s2;
	logic                       adv_s1;
	logic signed [zvf_pkg::CMP_W-1:0] lhs_x;
	logic signed [zvf_pkg::CMP_W-1:0] rhs_x;

	// a zero reference mean divides by one
	assign ref_nz = (cfg.ref_mean == '0) ? zvf_pkg::VAL_W'(1) : cfg.ref_mean;

	assign push      = valid_s2 && !q_full;
	assign adv_s2    = !valid_s2 || push;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign vox_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= vox_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vox_valid) begin
			mr_s1      <= 32'(vox.template_mean) * 32'(ref_nz);
			ts_s1      <= 32'(cfg.z_threshold) * 32'(vox.template_std);
			value_s1   <= vox.voxel_value;
			counted_s1 <= vox.in_roi && (vox.template_std != '0);
			last_s1    <= vox.last_voxel;
		end
		if (adv_s2 && valid_s1) begin
			lhs_s2     <= $signed({6'b0, value_s1, 24'b0}) - $signed({2'b0, mr_s1, 12'b0});
			tsr_s2     <= zvf_pkg::PROD_W'(ts_s1) * zvf_pkg::PROD_W'(ref_nz);
			counted_s2 <= counted_s1;
			last_s2    <= last_s1;
		end
	end

	assign lhs_x = zvf_pkg::CMP_W'(lhs_s2);
	assign rhs_x = $signed({2'b0, tsr_s2});

	always_comb begin
		push_data.counted = counted_s2;
		push_data.last    = last_s2;
		if (cfg.below_mode)
			push_data.pos = counted_s2 && (lhs_x < -rhs_x);
		else
			push_data.pos = counted_s2 && (lhs_x > rhs_x);
	end

endmodule
`default_nettype wire

[src/zvf_queue.sv]
// Four-entry queue of classified voxels between front and back end.
// Uses zvf_pkg for the entry type.
`default_nettype none
module zvf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire zvf_pkg::cls_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               nonempty,
	output zvf_pkg::cls_t      head
);

	zvf_pkg::cls_t entry_q [4];
	logic [1:0]    wr_q;
	logic [1:0]    rd_q;
	logic [2:0]    cnt_q;

	assign full     = (cnt_q == 3'd4);
	assign nonempty = (cnt_q != 3'd0);
	assign head     = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			if (push && !pop)
				cnt_q <= cnt_q + 3'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

[src/zvf_back.sv]
// Back end: saturating region and hit counts, result register, and a
// one-bit-per-cycle divider for the fill fraction on the last voxel. Uses zvf_pkg.
`default_nettype none
module zvf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_nonempty,
	input  wire zvf_pkg::cls_t head,
	output logic               pop,
	output logic               res_valid,
	input  wire logic          res_stall,
	output zvf_pkg::res_t      res
);

	typedef enum logic [1:0] {
		BK_RUN = 2'b01,
		BK_DIV = 2'b10
	} bk_state_t;

	localparam logic [zvf_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

	bk_state_t                       state_q;
	logic [zvf_pkg::COUNT_BITS-1:0]  region_q;
	logic [zvf_pkg::COUNT_BITS-1:0]  hit_q;
	logic [zvf_pkg::COUNT_BITS:0]    rem_q;
	logic [zvf_pkg::FRAC_W-1:0]      quo_q;
	logic [zvf_pkg::STEP_W-1:0]      step_q;
	logic                            res_valid_q;
	zvf_pkg::res_t                   res_q;
	logic                            free;
	logic [zvf_pkg::COUNT_BITS-1:0]  region_nx;
	logic [zvf_pkg::COUNT_BITS-1:0]  hit_nx;
	logic [zvf_pkg::COUNT_BITS:0]    trial;
	logic [zvf_pkg::COUNT_BITS:0]    diff;
	logic                            qbit;
	logic [zvf_pkg::FRAC_W-1:0]      quo_nx;

	assign free      = !res_valid_q || !res_stall;
	assign pop       = (state_q == BK_RUN) && q_nonempty && free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		region_nx = region_q;
		hit_nx    = hit_q;
		if (head.counted && region_q != CNT_MAX)
			region_nx = region_q + zvf_pkg::COUNT_BITS'(1);
		if (head.pos && hit_q != CNT_MAX)
			hit_nx = hit_q + zvf_pkg::COUNT_BITS'(1);
	end

	// first step takes the integer bit, later steps shift in a zero
	assign trial  = (step_q == '0) ? rem_q : {rem_q[zvf_pkg::COUNT_BITS-1:0], 1'b0};
	assign diff   = trial - {1'b0, region_q};
	assign qbit   = (trial >= {1'b0, region_q});
	assign quo_nx = {quo_q[zvf_pkg::FRAC_W-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			region_q    <= '0;
			hit_q       <= '0;
			res_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			unique case (state_q)
				BK_RUN: begin
					if (pop) begin
						if (head.last && region_nx != '0) begin
							state_q     <= BK_DIV;
							region_q    <= region_nx;
							hit_q       <= hit_nx;
							step_q      <= '0;
							res_valid_q <= 1'b0;
						end else if (head.last) begin
							region_q    <= '0;
							hit_q       <= '0;
							res_valid_q <= 1'b1;
						end else begin
							region_q    <= region_nx;
							hit_q       <= hit_nx;
							res_valid_q <= 1'b1;
						end
					end else if (free) begin
						res_valid_q <= 1'b0;
					end
				end
				BK_DIV: begin
					if (step_q == zvf_pkg::STEP_W'(zvf_pkg::FRACTION_BITS)) begin
						state_q     <= BK_RUN;
						region_q    <= '0;
						hit_q       <= '0;
						res_valid_q <= 1'b1;
					end else begin
						step_q <= step_q + zvf_pkg::STEP_W'(1);
					end
				end
				default: state_q <= BK_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.mask_bit       <= head.pos;
			res_q.counted_total  <= region_nx;
			res_q.positive_total <= hit_nx;
			res_q.fill_fraction  <= '0;
			res_q.image_done     <= head.last;
			rem_q                <= {1'b0, hit_nx};
			quo_q                <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= qbit ? diff : trial;
			quo_q <= quo_nx;
			if (step_q == zvf_pkg::STEP_W'(zvf_pkg::FRACTION_BITS))
				res_q.fill_fraction <= quo_nx;
		end
	end

endmodule
`default_nettype wire

[src/zscore_voxel_fraction.sv]
// Voxel z-score test with region fill fraction. An accepted voxel passes the front stages
// s1 and s2, the queue and the result register; one voxel per cycle sustained while the
// result side takes results and the divider is idle. The last voxel of an image with
// counted voxels runs the back-end serial divider, one quotient bit per cycle.
// Reset: configuration returns to its defaults, counts and queue clear.
`default_nettype none
module zscore_voxel_fraction (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vox_valid,
	output logic               vox_stall,
	input  wire zvf_pkg::vox_t vox,
	output logic               res_valid,
	input  wire logic          res_stall,
	output zvf_pkg::res_t      res,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);

	zvf_pkg::cfg_t cfg_q;
	logic          push;
	zvf_pkg::cls_t push_data;
	logic          q_full;
	logic          pop;
	logic          q_nonempty;
	zvf_pkg::cls_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_mean    <= zvf_pkg::REF_MEAN_RST;
			cfg_q.below_mode  <= 1'b0;
			cfg_q.z_threshold <= zvf_pkg::Z_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				zvf_pkg::REG_REF_MEAN:    cfg_q.ref_mean    <= cfg_data;
				zvf_pkg::REG_BELOW_MODE:  cfg_q.below_mode  <= cfg_data[0];
				zvf_pkg::REG_Z_THRESHOLD: cfg_q.z_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	zvf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.vox_valid (vox_valid),
		.vox_stall (vox_stall),
		.vox       (vox),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	zvf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head      (head)
	);

	zvf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule
`default_nettype wire

[dv/tb_zscore_voxel_fraction.sv]
`timescale 1ns / 1ps
// Testbench for zscore_voxel_fraction. A directed voxel table runs first, then random images
// under several register settings. Typed rows check listed values, others a local model.
// Depends on src/zvf_pkg.sv and src/zscore_voxel_fraction.sv.
module tb_zscore_voxel_fraction;
	import zvf_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int PHASES = 7;
	localparam longint CYCLE_LIMIT = 400000;

	typedef enum {ROW_VOXEL, ROW_CONFIG} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		vox_t        vx;
		bit          typed;
		res_t        want;
		logic [1:0]  idx;
		logic [15:0] data;
	} stim_row_t;

	typedef struct {
		bit   typed;
		res_t want;
	} voxel_note_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        vox_valid = 1'b0;
	logic        vox_stall;
	vox_t        vox = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_REF_MEAN;
	logic [15:0] cfg_data = '0;

	cfg_t                  cfg_model = '{REF_MEAN_RST, 1'b0, Z_THRESHOLD_RST};
	logic [COUNT_BITS-1:0] region_total = '0;
	logic [COUNT_BITS-1:0] hit_total = '0;

	res_t        results_due[$];
	voxel_note_t notes_due[$];
	stim_row_t   rows[$];

	int     send_idle_pct = 26;
	int     recv_idle_pct = 52;
	int     hold_asks = 0;
	int     hold_seen = 0;
	int     hold_left = 0;
	int     errors = 0;
	longint cycle_count = 0;

	voxel_note_t note;
	res_t        due;
	res_t        head_due;

	zscore_voxel_fraction dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vox_valid (vox_valid),
		.vox_stall (vox_stall),
		.vox       (vox),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Score one voxel, advance the region and hit counts, clear them on the last voxel.
	function automatic res_t score_voxel(input vox_t vx);
		res_t        r;
		longint      div;
		longint      lhs;
		longint      rhs;
		bit          hit;
		logic [63:0] frac;
		r = '0;
		if (vx.in_roi && vx.template_std != 0) begin
			div = (cfg_model.ref_mean == 0) ? 1 : longint'(cfg_model.ref_mean);
			lhs = (longint'(vx.voxel_value) <<< 24)
				- ((longint'(vx.template_mean) * div) <<< 12);
			rhs = longint'(cfg_model.z_threshold) * longint'(vx.template_std) * div;
			hit = cfg_model.below_mode ? (lhs < -rhs) : (lhs > rhs);
			if (region_total != '1)
				region_total = region_total + 1'b1;
			if (hit) begin
				r.mask_bit = 1'b1;
				if (hit_total != '1)
					hit_total = hit_total + 1'b1;
			end
		end
		r.counted_total = region_total;
		r.positive_total = hit_total;
		r.image_done = vx.last_voxel;
		if (vx.last_voxel && region_total != 0) begin
			frac = (64'(hit_total) << FRACTION_BITS) / 64'(region_total);
			r.fill_fraction = frac[FRAC_W-1:0];
		end
		if (vx.last_voxel) begin
			region_total = '0;
			hit_total = '0;
		end
		return r;
	endfunction

	function automatic vox_t draw_voxel(input longint ref_div);
		vox_t   vx;
		longint centre;
		int     span;
		vx.voxel_value = 16'($urandom);
		centre = (longint'(vx.voxel_value) * 4096) / ref_div;
		case ($urandom_range(3))
			0: span = 64;
			1: span = 2048;
			2: span = 32768;
			default: span = 0;
		endcase
		if (span == 0) begin
			vx.template_mean = 16'($urandom);
		end else begin
			// center the mean on the scaled intensity so both outcomes stay likely
			centre = centre + longint'(int'($urandom_range(2 * span)) - span);
			if (centre < 0)
				centre = 0;
			if (centre > 65535)
				centre = 65535;
			vx.template_mean = 16'(centre);
		end
		case ($urandom_range(9))
			0: vx.template_std = '0;
			1, 2: vx.template_std = 16'($urandom);
			3, 4, 5: vx.template_std = 16'($urandom_range(512, 1));
			default: vx.template_std = 16'($urandom_range(4096, 1));
		endcase
		vx.in_roi = ($urandom_range(99) < 85);
		vx.last_voxel = ($urandom_range(15) == 0);
		return vx;
	endfunction

	function automatic void add_voxel(input int v, input int m, input int s, input bit roi,
			input bit last, input bit typed, input bit mask = 0, input int cnt = 0,
			input int pos = 0, input int frac = 0);
		stim_row_t row;
		row.kind = ROW_VOXEL;
		row.vx = '{16'(v), 16'(m), 16'(s), roi, last};
		row.typed = typed;
		row.want = '{mask, COUNT_BITS'(cnt), COUNT_BITS'(pos), FRAC_W'(frac), last};
		row.idx = REG_UNUSED;
		row.data = '0;
		rows.push_back(row);
	endfunction

	function automatic void add_reg(input logic [1:0] idx, input int data);
		stim_row_t row;
		row.kind = ROW_CONFIG;
		row.vx = '0;
		row.typed = 1'b0;
		row.want = '0;
		row.idx = idx;
		row.data = 16'(data);
		rows.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic push_voxel(input vox_t vx, input bit typed, input res_t want);
		voxel_note_t n;
		while ($urandom_range(99) < send_idle_pct) begin
			vox_valid <= 1'b0;
			@(posedge clk);
		end
		n.typed = typed;
		n.want = want;
		notes_due.push_back(n);
		vox_valid <= 1'b1;
		vox <= vx;
		@(posedge clk);
		while (vox_stall)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and wait until every due result has come back and the divider is done.
	task automatic settle();
		vox_valid <= 1'b0;
		while (results_due.size() != 0 || notes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Voxel and register acceptance: predict at the edge that takes the item.
	always @(posedge clk) begin
		if (arst_n && vox_valid && !vox_stall) begin
			note = notes_due.pop_front();
			due = score_voxel(vox);
			results_due.push_back(note.typed ? note.want : due);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REF_MEAN: cfg_model.ref_mean = cfg_data;
				REG_BELOW_MODE: cfg_model.below_mode = cfg_data[0];
				REG_Z_THRESHOLD: cfg_model.z_threshold = cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (results_due.size() == 0) begin
				flag_mismatch("result with none due", 1, 0);
			end else begin
				head_due = results_due.pop_front();
				if (res.mask_bit !== head_due.mask_bit)
					flag_mismatch("mask_bit", res.mask_bit, head_due.mask_bit);
				if (res.counted_total !== head_due.counted_total)
					flag_mismatch("counted_total", res.counted_total,
						head_due.counted_total);
				if (res.positive_total !== head_due.positive_total)
					flag_mismatch("positive_total", res.positive_total,
						head_due.positive_total);
				if (res.fill_fraction !== head_due.fill_fraction)
					flag_mismatch("fill_fraction", res.fill_fraction,
						head_due.fill_fraction);
				if (res.image_done !== head_due.image_done)
					flag_mismatch("image_done", res.image_done, head_due.image_done);
			end
		end
	end

	// Result side: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [15:0] ph_ref;
		logic        ph_below;
		logic [15:0] ph_thr;
		res_t        none;
		none = '0;

		// default settings: above mode, threshold 1.65, ref_mean 4096
		add_voxel(1234, 100, 50, 0, 0, 1, 0, 0, 0, 0);
		add_voxel(65535, 0, 0, 1, 0, 1, 0, 0, 0, 0);
		add_voxel(65535, 0, 1, 1, 0, 1, 1, 1, 1, 0);
		add_voxel(0, 65535, 65535, 1, 0, 1, 0, 2, 1, 0);
		add_voxel(0, 0, 0, 0, 1, 1, 0, 2, 1, 32768);
		// last voxel of an image with nothing counted
		add_voxel(500, 500, 500, 0, 1, 1, 0, 0, 0, 0);
		// z exactly at the threshold is not positive
		add_voxel(6758, 0, 4096, 1, 0, 1, 0, 1, 0, 0);
		add_voxel(6759, 0, 4096, 1, 0, 1, 1, 2, 1, 0);
		add_voxel(65535, 0, 4096, 1, 1, 1, 1, 3, 2, 43690);
		// every counted voxel positive: fraction needs the wide bit
		add_voxel(65535, 0, 1, 1, 1, 1, 1, 1, 1, 65536);
		add_reg(REG_BELOW_MODE, 1);
		add_reg(REG_Z_THRESHOLD, 0);
		add_voxel(100, 100, 1, 1, 0, 0);
		add_voxel(99, 100, 1, 1, 0, 0);
		add_voxel(0, 65535, 65535, 1, 1, 0);
		// zero ref_mean acts as a divisor of one
		add_reg(REG_REF_MEAN, 0);
		add_voxel(1, 4096, 1, 1, 0, 0);
		add_voxel(0, 1, 65535, 1, 1, 0);
		add_reg(REG_REF_MEAN, 65535);
		add_reg(REG_Z_THRESHOLD, 65535);
		add_reg(REG_BELOW_MODE, 0);
		add_reg(REG_UNUSED, 65535);
		add_voxel(65535, 0, 1, 1, 1, 0);
		add_voxel(65535, 65535, 65535, 1, 1, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CONFIG) begin
				settle();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				push_voxel(rows[i].vx, rows[i].typed, rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				send_idle_pct = 52;
				recv_idle_pct = 26;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: begin ph_ref = REF_MEAN_RST; ph_below = 0; ph_thr = Z_THRESHOLD_RST; end
				1: begin ph_ref = 16'd1; ph_below = 1; ph_thr = 16'd0; end
				2: begin ph_ref = 16'd65535; ph_below = 0; ph_thr = 16'd65535; end
				3: begin ph_ref = 16'd0; ph_below = 1; ph_thr = Z_THRESHOLD_RST; end
				default: begin
					ph_ref = 16'($urandom_range(65535, 1));
					ph_below = 1'($urandom);
					ph_thr = 16'($urandom_range(16384));
				end
			endcase
			settle();
			write_reg(REG_REF_MEAN, ph_ref);
			write_reg(REG_BELOW_MODE, {15'd0, ph_below});
			write_reg(REG_Z_THRESHOLD, ph_thr);
			// hold the result side while voxels keep coming so the input backs up
			if (p == 5)
				hold_asks++;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				push_voxel(draw_voxel((ph_ref == 0) ? 1 : longint'(ph_ref)), 1'b0, none);
		end

		settle();
		if (errors == 0 && results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[zscore_voxel_fraction.f]
src/zvf_pkg.sv
src/zvf_front.sv
src/zvf_queue.sv
src/zvf_back.sv
src/zscore_voxel_fraction.sv
dv/tb_zscore_voxel_fraction.sv
